### rtl/nses_pkg.sv
// shared types and constants for the nearest smaller value block
package nses_pkg;

    localparam int MAX_LEN      = 64;
    localparam int HEIGHT_WIDTH = 32;
    localparam int IDX_W        = $clog2(MAX_LEN);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OUT_IDX_W    = 7;
    localparam logic [OUT_IDX_W-1:0] NO_INDEX = 7'h7f;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LPOP_RD,
        ST_LPOP_CMP,
        ST_RSETUP,
        ST_RPOP_RD,
        ST_RPOP_CMP,
        ST_EMIT_RD,
        ST_EMIT_HT,
        ST_EMIT_OUT
    } nses_state_t;

    typedef struct packed {
        logic load;         // capture input item
        logic lpop_rd;      // read height of left stack top
        logic lpop;         // pop left stack
        logic lpush;        // store item, push index
        logic drop;         // overflowed item
        logic rstart;       // init right pass
        logic rpop_rd;
        logic rpop;
        logic rpush;
        logic emit_rd;      // read left/right/heights for position
        logic emit_ht;
        logic emit_out;     // load output register
        logic finish;       // clear counts
    } nses_cmd_t;

    typedef struct packed {
        logic full;
        logic lstack_empty;
        logic lpop_hit;     // top height >= new key
        logic rstack_empty;
        logic rpop_hit;
        logic rdone;        // right pass finished
        logic edone;        // last position emitted
        logic is_last;
        logic out_busy;
    } nses_stat_t;

endpackage

### rtl/nses_ram.sv
// generic single write, single registered read memory
module nses_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // write-first: a read of the address being written returns the new word
        rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end

endmodule

### rtl/nses_ctrl.sv
// sequencing state machine for load, right pass and emission
module nses_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  nses_pkg::nses_stat_t stat,
    output logic                 in_ready,
    output nses_pkg::nses_cmd_t  cmd
);

    nses_pkg::nses_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nses_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            nses_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (stat.full)
                    begin
                        cmd.drop = 1'b1;
                        state_next = nses_pkg::ST_LPOP_CMP;
                    end
                    else
                    begin
                        state_next = nses_pkg::ST_LPOP_RD;
                    end
                end
            end
            nses_pkg::ST_LPOP_RD:
            begin
                if (stat.lstack_empty)
                begin
                    cmd.lpush = 1'b1;
                    state_next = stat.is_last ? nses_pkg::ST_RSETUP : nses_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.lpop_rd = 1'b1;
                    state_next = nses_pkg::ST_LPOP_CMP;
                end
            end
            nses_pkg::ST_LPOP_CMP:
            begin
                if (stat.full)
                begin
                    // dropped item: only the end marker matters
                    state_next = stat.is_last ? nses_pkg::ST_RSETUP : nses_pkg::ST_IDLE;
                end
                else if (stat.lpop_hit)
                begin
                    cmd.lpop = 1'b1;
                    state_next = nses_pkg::ST_LPOP_RD;
                end
                else
                begin
                    cmd.lpush = 1'b1;
                    state_next = stat.is_last ? nses_pkg::ST_RSETUP : nses_pkg::ST_IDLE;
                end
            end
            nses_pkg::ST_RSETUP:
            begin
                cmd.rstart = 1'b1;
                state_next = nses_pkg::ST_RPOP_RD;
            end
            nses_pkg::ST_RPOP_RD:
            begin
                if (stat.rdone)
                begin
                    state_next = nses_pkg::ST_EMIT_RD;
                end
                else if (stat.rstack_empty)
                begin
                    cmd.rpush = 1'b1;
                end
                else
                begin
                    cmd.rpop_rd = 1'b1;
                    state_next = nses_pkg::ST_RPOP_CMP;
                end
            end
            nses_pkg::ST_RPOP_CMP:
            begin
                if (stat.rpop_hit)
                begin
                    cmd.rpop = 1'b1;
                end
                else
                begin
                    cmd.rpush = 1'b1;
                end
                state_next = nses_pkg::ST_RPOP_RD;
            end
            nses_pkg::ST_EMIT_RD:
            begin
                if (stat.edone)
                begin
                    cmd.finish = 1'b1;
                    state_next = nses_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                    state_next = nses_pkg::ST_EMIT_HT;
                end
            end
            nses_pkg::ST_EMIT_HT:
            begin
                cmd.emit_ht = 1'b1;
                state_next = nses_pkg::ST_EMIT_OUT;
            end
            nses_pkg::ST_EMIT_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_out = 1'b1;
                    state_next = nses_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = nses_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/nses_dp.sv
// datapath: stores, stacks, compare and output register
module nses_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nses_pkg::nses_cmd_t                 cmd,
    input  logic [nses_pkg::HEIGHT_WIDTH-1:0]   in_height,
    input  logic                                in_last,
    input  logic                                out_ready,
    output nses_pkg::nses_stat_t                stat,
    output logic                                out_valid,
    output logic [nses_pkg::OUT_IDX_W-1:0]      out_index,
    output logic                                out_last,
    output logic                                out_ovf
);

    localparam int IW = nses_pkg::IDX_W;
    localparam int CW = nses_pkg::CNT_W;
    localparam int HW = nses_pkg::HEIGHT_WIDTH;
    localparam int OW = nses_pkg::OUT_IDX_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ldepth_reg, ldepth_next;
    logic [CW-1:0] rdepth_reg, rdepth_next;
    logic [CW-1:0] rpos_reg, rpos_next;   // positions left to scan, counts down
    logic [CW-1:0] epos_reg, epos_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;
    logic [HW-1:0] key_reg, key_next;
    logic          ov_valid_reg, ov_valid_next;
    logic [OW-1:0] ov_index_reg, ov_index_next;
    logic          ov_last_reg, ov_last_next;
    logic          ov_ovf_reg, ov_ovf_next;
    logic [OW-1:0] eleft_reg, eright_reg;
    logic [OW-1:0] pick_reg;

    // stores
    logic          h_we;
    logic [IW-1:0] h_waddr, h_raddr;
    logic [HW-1:0] h_rdata;
    logic          h2_we;
    logic [IW-1:0] h2_raddr;
    logic [HW-1:0] h2_rdata;
    logic          ln_we;
    logic [OW-1:0] ln_wdata, ln_rdata;
    logic [IW-1:0] ln_raddr;
    logic          ls_we;
    logic [IW-1:0] ls_waddr, ls_raddr, ls_rdata;
    logic          rs_we;
    logic [IW-1:0] rs_waddr, rs_raddr, rs_rdata;
    logic          rr_we;
    logic [OW-1:0] rr_wdata, rr_rdata;
    logic [IW-1:0] rr_waddr;

    logic [IW-1:0] cur_pos, rcur;
    logic [OW-1:0] lnear, rnear, pick;
    logic [OW-1:0] dl, dr, epos_w;

    assign cur_pos = count_reg[IW-1:0];
    assign rcur    = IW'(rpos_reg - 1'b1);
    assign epos_w  = OW'(epos_reg);

    // height store, two copies so two heights can be read at once
    assign h_we    = cmd.lpush;
    assign h_waddr = cur_pos;
    assign h2_we   = cmd.lpush;

    always_comb
    begin
        h_raddr  = ls_rdata;
        h2_raddr = ls_rdata;
        if (cmd.rpop_rd || cmd.rpush || cmd.rstart)
        begin
            h_raddr = rs_rdata;
            h2_raddr = rcur;
        end
        if (cmd.emit_rd || cmd.emit_ht)
        begin
            h_raddr  = ln_rdata[IW-1:0];
            h2_raddr = rr_rdata[IW-1:0];
        end
    end

    nses_ram #(.WIDTH(HW), .DEPTH(nses_pkg::MAX_LEN)) u_height (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(key_reg),
        .raddr(h_raddr), .rdata(h_rdata));

    nses_ram #(.WIDTH(HW), .DEPTH(nses_pkg::MAX_LEN)) u_height2 (
        .clk(clk), .we(h2_we), .waddr(h_waddr), .wdata(key_reg),
        .raddr(h2_raddr), .rdata(h2_rdata));

    // left stack and left answers; top is read ahead from the next depth
    assign ls_raddr = IW'(ldepth_next - 1'b1);
    assign ls_we    = cmd.lpush;
    assign ls_waddr = ldepth_reg[IW-1:0];
    assign lnear    = (ldepth_reg == '0) ? nses_pkg::NO_INDEX : OW'(ls_rdata);
    assign ln_we    = cmd.lpush;
    assign ln_wdata = lnear;
    assign ln_raddr = epos_next[IW-1:0];

    nses_ram #(.WIDTH(IW), .DEPTH(nses_pkg::MAX_LEN)) u_lstack (
        .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(cur_pos),
        .raddr(ls_raddr), .rdata(ls_rdata));

    nses_ram #(.WIDTH(OW), .DEPTH(nses_pkg::MAX_LEN)) u_lnear (
        .clk(clk), .we(ln_we), .waddr(cur_pos), .wdata(ln_wdata),
        .raddr(ln_raddr), .rdata(ln_rdata));

    // right stack and right answers
    assign rs_raddr = IW'(rdepth_next - 1'b1);
    assign rs_we    = cmd.rpush;
    assign rs_waddr = rdepth_reg[IW-1:0];
    assign rnear    = (rdepth_reg == '0) ? nses_pkg::NO_INDEX : OW'(rs_rdata);
    assign rr_we    = cmd.rpush;
    assign rr_waddr = rcur;
    assign rr_wdata = rnear;

    nses_ram #(.WIDTH(IW), .DEPTH(nses_pkg::MAX_LEN)) u_rstack (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rcur),
        .raddr(rs_raddr), .rdata(rs_rdata));

    nses_ram #(.WIDTH(OW), .DEPTH(nses_pkg::MAX_LEN)) u_rnear (
        .clk(clk), .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
        .raddr(ln_raddr), .rdata(rr_rdata));

    // choice between left and right
    assign dl = OW'(epos_w - eleft_reg);
    assign dr = OW'(eright_reg - epos_w);

    always_comb
    begin
        priority if (eleft_reg == nses_pkg::NO_INDEX && eright_reg == nses_pkg::NO_INDEX)
        begin
            pick = nses_pkg::NO_INDEX;
        end
        else if (eright_reg == nses_pkg::NO_INDEX)
        begin
            pick = eleft_reg;
        end
        else if (eleft_reg == nses_pkg::NO_INDEX)
        begin
            pick = eright_reg;
        end
        else if (dl < dr)
        begin
            pick = eleft_reg;
        end
        else if (dr < dl)
        begin
            pick = eright_reg;
        end
        else
        begin
            pick = (h2_rdata >= h_rdata) ? eleft_reg : eright_reg;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        ldepth_next   = ldepth_reg;
        rdepth_next   = rdepth_reg;
        rpos_next     = rpos_reg;
        epos_next     = epos_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        key_next      = key_reg;
        ov_valid_next = ov_valid_reg;
        ov_index_next = ov_index_reg;
        ov_last_next  = ov_last_reg;
        ov_ovf_next   = ov_ovf_reg;
        if (ov_valid_reg && out_ready)
        begin
            ov_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            key_next  = in_height ^ {1'b1, {(HW-1){1'b0}}};
            last_next = in_last;
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.lpop)
        begin
            ldepth_next = ldepth_reg - 1'b1;
        end
        if (cmd.lpush)
        begin
            ldepth_next = ldepth_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (cmd.rstart)
        begin
            rpos_next   = count_reg;
            rdepth_next = '0;
            epos_next   = '0;
        end
        if (cmd.rpop)
        begin
            rdepth_next = rdepth_reg - 1'b1;
        end
        if (cmd.rpush)
        begin
            rdepth_next = rdepth_reg + 1'b1;
            rpos_next   = rpos_reg - 1'b1;
        end
        if (cmd.emit_out)
        begin
            ov_valid_next = 1'b1;
            ov_index_next = pick_reg;
            ov_last_next  = (epos_reg + 1'b1 == count_reg);
            ov_ovf_next   = ovf_reg;
            epos_next     = epos_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            count_next  = '0;
            ldepth_next = '0;
            epos_next   = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ldepth_reg   <= '0;
            rdepth_reg   <= '0;
            rpos_reg     <= '0;
            epos_reg     <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ldepth_reg   <= ldepth_next;
            rdepth_reg   <= rdepth_next;
            rpos_reg     <= rpos_next;
            epos_reg     <= epos_next;
            ovf_reg      <= ovf_next;
            last_reg     <= last_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        ov_index_reg <= ov_index_next;
        ov_last_reg  <= ov_last_next;
        ov_ovf_reg   <= ov_ovf_next;
        if (cmd.emit_rd)
        begin
            eleft_reg  <= ln_rdata;
            eright_reg <= rr_rdata;
        end
        // heights of both candidates are valid here, hold the choice over stalls
        if (cmd.emit_ht)
        begin
            pick_reg <= pick;
        end
    end

    assign stat.full         = (count_reg == CW'(nses_pkg::MAX_LEN));
    assign stat.lstack_empty = (ldepth_reg == '0);
    assign stat.lpop_hit     = (h_rdata >= key_reg);
    assign stat.rstack_empty = (rdepth_reg == '0);
    assign stat.rpop_hit     = (h_rdata >= h2_rdata);
    assign stat.rdone        = (rpos_reg == '0);
    assign stat.edone        = (epos_reg == count_reg);
    assign stat.is_last      = last_reg;
    assign stat.out_busy     = ov_valid_reg && !out_ready;

    assign out_valid = ov_valid_reg;
    assign out_index = ov_index_reg;
    assign out_last  = ov_last_reg;
    assign out_ovf   = ov_ovf_reg;

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ldepth_reg <= count_reg)
        else $error("left stack deeper than item count");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        epos_reg <= count_reg)
        else $error("emission ran past item count");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_out |-> !(ov_valid_reg && !out_ready))
        else $error("output register overwritten");
`endif

endmodule

### rtl/nearest_smaller_either_side.sv
// top level: nearest smaller value on either side of each stored height
//
// channel   dir  payload
// s_axis    in   tdata[31:0] height, tlast last
// m_axis    out  tdata[6:0] nearest_index, tdata[7] overflow, tlast last_res
//
// a load captures the height, reads the left-stack top and compares it, pops the top
// while it is not smaller and reads again, then pushes the new index
// on the final transfer a right pass runs, reading, comparing and popping per position,
// then each result is read from the single-read stores, chosen and registered, waiting under stall
// s_axis_tready is high only while idle; the output register holds under stall
// asynchronous active-low reset clears counts and stack depths
module nearest_smaller_either_side (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // height
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // nearest_index[6:0], overflow[7]
    output logic        m_axis_tlast
);

    nses_pkg::nses_cmd_t  cmd;
    nses_pkg::nses_stat_t stat;
    logic                 in_fire;
    logic [6:0]           idx;
    logic                 ovf;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    nses_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .stat(stat),
        .in_ready(s_axis_tready), .cmd(cmd));

    nses_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_height(s_axis_tdata[nses_pkg::HEIGHT_WIDTH-1:0]),
        .in_last(s_axis_tlast), .out_ready(m_axis_tready), .stat(stat),
        .out_valid(m_axis_tvalid), .out_index(idx), .out_last(m_axis_tlast),
        .out_ovf(ovf));

    assign m_axis_tdata = {ovf, idx};

endmodule

### tb/sv/nearest_smaller_either_side_tb.sv
// testbench for the nearest smaller value block: directed and random sequences
module nearest_smaller_either_side_tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // height
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // nearest_index[6:0], overflow[7]
    logic        m_axis_tlast;

    typedef struct packed {
        logic [nses_pkg::OUT_IDX_W-1:0] nearest_index;
        logic                           last_res;
        logic                           overflow;
    } nearest_result_t;

    nearest_smaller_either_side i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state: heights of the sequence loaded so far
    logic signed [nses_pkg::HEIGHT_WIDTH-1:0] seq_heights[$];
    logic                                     seq_overflow;
    nearest_result_t                          expected_results[$];

    int  mismatch_count;
    int  cycle_count;
    bit  hold_off;
    int  hold_cycles;

    localparam int CYCLE_LIMIT = 400000;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nearest_smaller_either_side test failed");
            $finish;
        end
    end

    // work out all results of the sequence when its final height arrives
    task automatic resolve_sequence();
        int n;
        int left_idx;
        int right_idx;
        int pick;
        n = seq_heights.size();
        for (int i = 0; i < n; i++)
        begin
            nearest_result_t r;
            left_idx = -1;
            right_idx = -1;
            for (int j = i - 1; j >= 0; j--)
                if (seq_heights[j] < seq_heights[i])
                begin
                    left_idx = j;
                    break;
                end
            for (int j = i + 1; j < n; j++)
                if (seq_heights[j] < seq_heights[i])
                begin
                    right_idx = j;
                    break;
                end
            if (left_idx < 0)
                pick = right_idx;
            else if (right_idx < 0)
                pick = left_idx;
            else if (i - left_idx < right_idx - i)
                pick = left_idx;
            else if (right_idx - i < i - left_idx)
                pick = right_idx;
            else
                pick = (seq_heights[right_idx] >= seq_heights[left_idx]) ? left_idx
                                                                           : right_idx;
            r.nearest_index = (pick < 0) ? nses_pkg::NO_INDEX
                                         : pick[nses_pkg::OUT_IDX_W-1:0];
            r.last_res      = (i == n - 1);
            r.overflow      = seq_overflow;
            expected_results.insert(expected_results.size(), r);
        end
        seq_heights.delete();
        seq_overflow = 1'b0;
    endtask

    // send one height, waiting a random gap first
    task automatic send_height(input logic [31:0] height, input bit last);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= height;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // transfer accepted at this edge
        if (seq_heights.size() < nses_pkg::MAX_LEN)
            seq_heights.insert(seq_heights.size(), height);
        else
            seq_overflow = 1'b1;
        if (last)
            resolve_sequence();
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_height(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 7);
            2: return 32'($urandom_range(0, 7)) - 32'd4;
            default: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff8}
                            + 32'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_sequence(input int len, input int mode);
        for (int i = 0; i < len; i++)
            send_height(rand_height(mode), i == len - 1);
    endtask

    // receiver: random wait per transfer, or a long hold-off when asked
    initial
    begin
        int wait_cycles;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(0, 9);
            if (hold_off)
            begin
                wait_cycles = hold_cycles;
                hold_off = 1'b0;
            end
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            nearest_result_t got;
            nearest_result_t want;
            got.nearest_index = m_axis_tdata[6:0];
            got.overflow      = m_axis_tdata[7];
            got.last_res      = m_axis_tlast;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result idx=%0d last=%0b ovf=%0b",
                             got.nearest_index, got.last_res, got.overflow);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected idx=%0d last=%0b ovf=%0b, ",
                                  "got idx=%0d last=%0b ovf=%0b"},
                                 want.nearest_index, want.last_res, want.overflow,
                                 got.nearest_index, got.last_res, got.overflow);
                end
            end
        end
    end

    task automatic test_directed();
        send_height(32'h0000_0005, 1'b1);                 // single position
        send_height(32'h7fff_ffff, 1'b0);                 // extremes
        send_height(32'h8000_0000, 1'b0);
        send_height(32'hffff_ffff, 1'b0);
        send_height(32'h0000_0000, 1'b1);
        // equal distances, smaller height on the right
        send_height(32'd3, 1'b0);
        send_height(32'd5, 1'b0);
        send_height(32'd2, 1'b1);
        // equal distances and equal heights picks the left
        send_height(32'd3, 1'b0);
        send_height(32'd5, 1'b0);
        send_height(32'd3, 1'b1);
        // all equal: none smaller anywhere
        repeat (3) send_height(32'd7, 1'b0);
        send_height(32'd7, 1'b1);
        // strictly decreasing then increasing
        for (int i = 0; i < 6; i++)
            send_height(32'd10 - 32'(i < 3 ? i : 6 - i), i == 5);
    endtask

    task automatic test_overflow();
        send_sequence(nses_pkg::MAX_LEN, 0);          // exactly full
        send_sequence(nses_pkg::MAX_LEN + 3, 2);      // truncated and flagged
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off = 1'b1;
        send_sequence(8, 1);
        send_sequence(6, 3);
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 95)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            send_sequence(len, $urandom_range(0, 3));
            sent += len;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        seq_overflow   = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_off       = 1'b0;
        hold_cycles    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("nearest_smaller_either_side test passed");
        else
            $display("nearest_smaller_either_side test failed");
        $finish;
    end

endmodule
